// ----- design/assert_macros.svh -----
// assertion macros shared by the allocator rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define CHK_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never be seen out of reset
`define CHK_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- design/p2sfl_pkg.sv -----
// types and constants of the size class free list allocator
`default_nettype none

package p2sfl_pkg;

    localparam int TRI_W  = 15;
    localparam int ADDR_W = 16;
    localparam int SCLS_W = 4;
    localparam int STAT_W = 2;
    // class values up to 33 plus the link flag position need six bits
    localparam int CLS_W  = 6;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    localparam logic [STAT_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_NO_SPACE  = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_BAD_CLASS = 2'd2;

    typedef struct packed {
        logic              func;
        logic [TRI_W-1:0]  tri_count;
        logic [ADDR_W-1:0] block_addr;
    } req_t;

    typedef struct packed {
        logic [ADDR_W-1:0] alloc_addr;
        logic [SCLS_W-1:0] size_class;
        logic [STAT_W-1:0] status;
    } rsp_t;

endpackage

`default_nettype wire

// ----- design/pow2_size_class_free_list_allocator.sv -----
// top level: power-of-two size class free list allocator over a word pool
// accept to result valid: carve, out of space, bad class via S_ALLOC or S_FREE_HDR only;
// pop via S_ALLOC, head memory read, then S_POP, dependent pool header read;
// good free via S_FREE_HDR, pool header read, then S_FREE_PUSH, dependent head read
// one item at a time, ready as its result turns valid; the next result waits until it is taken
// reset: all free lists empty, carve pointer zero; pool contents undefined, no clearing pass
`default_nettype none
`include "assert_macros.svh"

module pow2_size_class_free_list_allocator
    import p2sfl_pkg::*;
#(
    parameter int NUM_CLASSES    = 15,
    parameter int POOL_ADDR_BITS = 16
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire req_t req,
    input  wire logic req_valid,
    output logic      req_ready,
    output rsp_t      rsp,
    output logic      rsp_valid,
    input  wire logic rsp_ready
);

    // header word: link flag above the address bits
    localparam int WORD_W = POOL_ADDR_BITS + 1;
    localparam int IDX_W  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    // room for carve pointer plus the largest capacity 3*2^c+1
    localparam int SUM_W  = ((POOL_ADDR_BITS > NUM_CLASSES) ? POOL_ADDR_BITS : NUM_CLASSES) + 3;
    localparam logic [SUM_W-1:0] POOL_WORDS = SUM_W'(1) << POOL_ADDR_BITS;
    localparam logic [CLS_W-1:0] CLS_LIMIT  = CLS_W'(NUM_CLASSES);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ALLOC,
        S_POP,
        S_FREE_HDR,
        S_FREE_PUSH
    } state_t;

    state_t                    state_reg, state_next;
    logic                      func_reg, func_next;
    logic [TRI_W-1:0]          count_reg, count_next;
    logic [CLS_W-1:0]          class_reg, class_next;
    logic [POOL_ADDR_BITS-1:0] addr_reg, addr_next;
    logic [WORD_W-1:0]         carve_reg, carve_next;
    logic                      rsp_valid_reg, rsp_valid_next;
    rsp_t                      rsp_reg, rsp_next;

    logic [CLS_W-1:0]          alloc_cls;
    logic [CLS_W-1:0]          hdr_cls;
    logic [POOL_ADDR_BITS-1:0] req_addr;
    logic                      out_free;
    logic                      req_take;

    logic [IDX_W-1:0]          head_rd_idx;
    logic [WORD_W-1:0]         head_word;
    logic                      head_we;
    logic [IDX_W-1:0]          head_wr_idx;
    logic [WORD_W-1:0]         head_wr_word;

    logic [POOL_ADDR_BITS-1:0] pool_rd_addr;
    logic [WORD_W-1:0]         pool_word;
    logic                      pool_we;
    logic [POOL_ADDR_BITS-1:0] pool_wr_addr;
    logic [WORD_W-1:0]         pool_wr_word;

    logic [SUM_W-1:0]          carve_cap;
    logic [SUM_W-1:0]          carve_sum;
    logic                      carve_fail;

    // class of the requested count, straight off the input item
    p2sfl_class_unit #(.IN_W(TRI_W)) u_alloc_cls (
        .value (req.tri_count),
        .cls   (alloc_cls)
    );

    // class of the header word read back by a free
    p2sfl_class_unit #(.IN_W(WORD_W)) u_hdr_cls (
        .value (pool_word),
        .cls   (hdr_cls)
    );

    p2sfl_head_mem #(
        .DEPTH  (NUM_CLASSES),
        .IDX_W  (IDX_W),
        .WORD_W (WORD_W)
    ) u_heads (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_idx  (head_rd_idx),
        .rd_word (head_word),
        .wr_en   (head_we),
        .wr_idx  (head_wr_idx),
        .wr_word (head_wr_word)
    );

    p2sfl_pool_mem #(
        .ADDR_BITS (POOL_ADDR_BITS),
        .WORD_W    (WORD_W)
    ) u_pool (
        .clk     (clk),
        .rd_addr (pool_rd_addr),
        .rd_word (pool_word),
        .wr_en   (pool_we),
        .wr_addr (pool_wr_addr),
        .wr_word (pool_wr_word)
    );

    assign req_addr = POOL_ADDR_BITS'(req.block_addr);
    assign out_free = !rsp_valid_reg || rsp_ready;
    assign req_take = req_valid && req_ready;

    // bump allocation check: block must end at or before the pool end
    assign carve_cap  = (SUM_W'(3) << class_reg) + SUM_W'(1);
    assign carve_sum  = SUM_W'(carve_reg) + carve_cap;
    assign carve_fail = carve_sum > POOL_WORDS;

    // sequencer: every memory write happens on the transition back to idle,
    // and a new item only starts from idle, so reads never overlap a
    // pending write to the same entry
    always_comb
    begin
        state_next     = state_reg;
        func_next      = func_reg;
        count_next     = count_reg;
        class_next     = class_reg;
        addr_next      = addr_reg;
        carve_next     = carve_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        req_ready      = 1'b0;

        head_rd_idx  = IDX_W'(class_reg);
        head_we      = 1'b0;
        head_wr_idx  = IDX_W'(class_reg);
        head_wr_word = pool_word;

        pool_rd_addr = addr_reg;
        pool_we      = 1'b0;
        pool_wr_addr = addr_reg;
        pool_wr_word = WORD_W'(count_reg);

        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                // look up both the list head and the freed header at once
                head_rd_idx  = (alloc_cls < CLS_LIMIT) ? IDX_W'(alloc_cls) : '0;
                pool_rd_addr = req_addr;
                if (req_valid)
                begin
                    func_next  = req.func;
                    count_next = req.tri_count;
                    class_next = alloc_cls;
                    addr_next  = req_addr;
                    state_next = (req.func == FUNC_ALLOC) ? S_ALLOC : S_FREE_HDR;
                end
            end

            S_ALLOC:
            begin
                if (class_reg >= CLS_LIMIT)
                begin
                    // count beyond the largest class
                    if (out_free)
                    begin
                        rsp_next       = '{alloc_addr: '0, size_class: '0,
                                           status: STATUS_BAD_CLASS};
                        rsp_valid_next = 1'b1;
                        state_next     = S_IDLE;
                    end
                end
                else if (head_word[POOL_ADDR_BITS])
                begin
                    // list not empty: fetch the link held in the head block
                    addr_next    = head_word[POOL_ADDR_BITS-1:0];
                    pool_rd_addr = head_word[POOL_ADDR_BITS-1:0];
                    state_next   = S_POP;
                end
                else if (out_free)
                begin
                    if (carve_fail)
                    begin
                        rsp_next = '{alloc_addr: '0, size_class: SCLS_W'(class_reg),
                                     status: STATUS_NO_SPACE};
                    end
                    else
                    begin
                        pool_we      = 1'b1;
                        pool_wr_addr = carve_reg[POOL_ADDR_BITS-1:0];
                        carve_next   = carve_sum[WORD_W-1:0];
                        rsp_next     = '{alloc_addr: ADDR_W'(carve_reg[POOL_ADDR_BITS-1:0]),
                                         size_class: SCLS_W'(class_reg),
                                         status: STATUS_OK};
                    end
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            S_POP:
            begin
                if (out_free)
                begin
                    // link becomes the new head, count goes into the header
                    head_we        = 1'b1;
                    head_wr_word   = pool_word;
                    pool_we        = 1'b1;
                    rsp_next       = '{alloc_addr: ADDR_W'(addr_reg),
                                       size_class: SCLS_W'(class_reg),
                                       status: STATUS_OK};
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            S_FREE_HDR:
            begin
                if (hdr_cls >= CLS_LIMIT)
                begin
                    // header holds a link or a bad count
                    if (out_free)
                    begin
                        rsp_next       = '{alloc_addr: '0, size_class: '0,
                                           status: STATUS_BAD_CLASS};
                        rsp_valid_next = 1'b1;
                        state_next     = S_IDLE;
                    end
                end
                else
                begin
                    class_next  = hdr_cls;
                    head_rd_idx = IDX_W'(hdr_cls);
                    state_next  = S_FREE_PUSH;
                end
            end

            S_FREE_PUSH:
            begin
                if (out_free)
                begin
                    // old head goes into the header, block becomes the head
                    pool_we        = 1'b1;
                    pool_wr_word   = head_word;
                    head_we        = 1'b1;
                    head_wr_word   = {1'b1, addr_reg};
                    rsp_next       = '{alloc_addr: '0, size_class: SCLS_W'(class_reg),
                                       status: STATUS_OK};
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            func_reg      <= FUNC_ALLOC;
            count_reg     <= '0;
            class_reg     <= '0;
            addr_reg      <= '0;
            carve_reg     <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            func_reg      <= func_next;
            count_reg     <= count_next;
            class_reg     <= class_next;
            addr_reg      <= addr_next;
            carve_reg     <= carve_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_reg       <= rsp_next;
        end
    end

    assign rsp       = rsp_reg;
    assign rsp_valid = rsp_valid_reg;

    // alloc goes on to the head lookup, free to the header lookup
    `CHK_ASSERT(a_accept_path, req_take |=> ((state_reg == S_ALLOC) == !func_reg), "wrong path")
    `CHK_ASSERT(a_carve_in_pool, SUM_W'(carve_reg) <= POOL_WORDS, "carve past pool end")
    `CHK_NEVER(a_write_in_idle, req_ready && (pool_we || head_we), "memory write while idle")
    `CHK_ASSERT(a_rsp_from_busy, $rose(rsp_valid_reg) |-> $past(state_reg) != S_IDLE, "idle result")

endmodule

`default_nettype wire

// ----- design/p2sfl_class_unit.sv -----
// ceiling log2 of a count, giving the size class
`default_nettype none

module p2sfl_class_unit
    import p2sfl_pkg::*;
#(
    parameter int IN_W = 15
)
(
    input  wire logic [IN_W-1:0]  value,
    output logic      [CLS_W-1:0] cls
);

    logic [IN_W-1:0] less_one;

    assign less_one = value - IN_W'(1);

    // bit length of value minus one, zero and one map to class zero
    always_comb
    begin
        cls = '0;
        if (value > IN_W'(1))
        begin
            for (int i = 0; i < IN_W; i++)
            begin
                if (less_one[i])
                begin
                    cls = CLS_W'(i + 1);
                end
            end
        end
    end

endmodule

`default_nettype wire

// ----- design/p2sfl_head_mem.sv -----
// list head memory with per-entry written flags
`default_nettype none

module p2sfl_head_mem
    import p2sfl_pkg::*;
#(
    parameter int DEPTH  = 15,
    parameter int IDX_W  = 4,
    parameter int WORD_W = 17
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [IDX_W-1:0]  rd_idx,
    output logic      [WORD_W-1:0] rd_word,
    input  wire logic              wr_en,
    input  wire logic [IDX_W-1:0]  wr_idx,
    input  wire logic [WORD_W-1:0] wr_word
);

    logic [WORD_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]  written_reg;
    logic [WORD_W-1:0] rd_q_reg;
    logic              rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_word;
        end
        rd_q_reg <= mem[rd_idx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
            rd_vld_reg  <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                written_reg[wr_idx] <= 1'b1;
            end
            rd_vld_reg <= written_reg[rd_idx];
        end
    end

    // an entry never written reads as an empty list
    assign rd_word = rd_vld_reg ? rd_q_reg : '0;

endmodule

`default_nettype wire

// ----- design/p2sfl_pool_mem.sv -----
// pool header word memory, one read and one write port
`default_nettype none

module p2sfl_pool_mem
    import p2sfl_pkg::*;
#(
    parameter int ADDR_BITS = 16,
    parameter int WORD_W    = 17
)
(
    input  wire logic                 clk,
    input  wire logic [ADDR_BITS-1:0] rd_addr,
    output logic      [WORD_W-1:0]    rd_word,
    input  wire logic                 wr_en,
    input  wire logic [ADDR_BITS-1:0] wr_addr,
    input  wire logic [WORD_W-1:0]    wr_word
);

    logic [WORD_W-1:0] mem [2**ADDR_BITS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_word;
        end
        rd_word <= mem[rd_addr];
    end

endmodule

`default_nettype wire
